/* hdl/dtoi_pkg.sv */
// Package for the double to integer converter: type codes and the stage record.
// No dependencies.
package dtoi_pkg;
   localparam logic [3:0] TYPE_INT8    = 4'd0;
   localparam logic [3:0] TYPE_INT16   = 4'd1;
   localparam logic [3:0] TYPE_INT32   = 4'd2;
   localparam logic [3:0] TYPE_INT64   = 4'd3;
   localparam logic [3:0] TYPE_UINT8   = 4'd4;
   localparam logic [3:0] TYPE_UINT16  = 4'd5;
   localparam logic [3:0] TYPE_UINT32  = 4'd6;
   localparam logic [3:0] TYPE_UINT64  = 4'd7;
   localparam logic [3:0] TYPE_LOGICAL = 4'd8;

   typedef struct packed {
      logic        neg;
      logic        nan;
      logic        big;
      logic        nonzero;
      logic [3:0]  ttype;
   } ctl_type;
endpackage

/* hdl/dtoi_round.sv */
// Two-stage magnitude rounding of a binary64 value, half away from zero.
// Depends on dtoi_pkg.
module dtoi_round import dtoi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  logic [63:0] in_bits,
   input  logic [3:0]  in_type,
   output logic        out_valid,
   output ctl_type     out_ctl,
   output logic [63:0] out_mag
);
   logic        v1_ff, v2_ff;
   ctl_type     c1_ff, c1_in, c2_ff;
   logic [10:0] e1_ff;
   logic [52:0] m1_ff;
   logic [63:0] mag2_ff, mag_in;
   logic [10:0] e;
   logic [5:0]  sh;
   logic [63:0] wide;
   logic [53:0] ext;

   // Stage one: decode the fields.
   always_comb begin
      e = in_bits[62:52];
      c1_in.neg = in_bits[63];
      c1_in.nan = (e == 11'h7FF) && (in_bits[51:0] != 52'd0);
      c1_in.big = (e == 11'h7FF) || (e >= 11'd1087);
      c1_in.nonzero = in_bits[62:0] != 63'd0;
      c1_in.ttype = in_type;
   end

   // Stage two: align the significand and add the rounding bit.
   always_comb begin
      wide = 64'd0;
      sh = 6'd0;
      ext = 54'd0;
      mag_in = 64'd0;
      if (e1_ff < 11'd1022) begin
         mag_in = 64'd0;
      end else if (e1_ff >= 11'd1075) begin
         wide = {11'd0, m1_ff};
         sh = 6'(e1_ff - 11'd1075);
         mag_in = wide << sh;
      end else begin
         // Keep one fraction bit, then add it to the integer part.
         sh = 6'(11'd1075 - e1_ff);
         ext = {m1_ff, 1'b0} >> sh;
         mag_in = {11'd0, ext[53:1]} + {63'd0, ext[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (advance) begin
         c1_ff <= c1_in;
         e1_ff <= e;
         m1_ff <= {1'b1, in_bits[51:0]};
         c2_ff <= c1_ff;
         mag2_ff <= mag_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_ctl = c2_ff;
   assign out_mag = mag2_ff;
endmodule

/* hdl/double_to_int_saturating_convert.sv */
// Top level of the double to integer saturating converter.
// Depends on dtoi_pkg and dtoi_round.
//
// Usage:
//   The req_ channel carries one binary64 word per cycle unless req_stall is high; the rsp_ channel
//   returns the integer word with saturated and was_nan flags. csr_ selects
//   the target type (0..3 int, 4..7 uint, 8 logical), written while idle.
// Pipeline: three stages (decode, align and round, clip); an accepted word is
//   registered in each stage in turn, and rsp_valid rises once it sits in
//   the clip stage register.
// Throughput: one word per cycle while rsp_stall does not freeze the pipeline.
// Stall: when rsp_stall holds a valid result the whole pipeline freezes;
//   req_stall is then high so no word is lost or repeated. Bubbles inside
//   the pipeline stay in place while it is frozen.
// Reset: synchronous; clears the valid bits and sets the type to int8.
module double_to_int_saturating_convert import dtoi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_value_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_bits,
   output logic        rsp_saturated,
   output logic        rsp_was_nan,
   input  logic        csr_write,
   input  logic [3:0]  csr_wdata
);
   logic [3:0]  type_ff;
   logic        advance;
   logic        rv;
   ctl_type     rc;
   logic [63:0] rmag;
   logic        v3_ff;
   logic [63:0] res3_ff, res_in;
   logic        sat3_ff, sat_in, nan3_ff, nan_in;
   logic [63:0] lim, maxv;
   logic [1:0]  wsel;

   // Freeze only when an output result waits.
   assign advance = !(v3_ff && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff <= TYPE_INT8;
      end else if (csr_write) begin
         type_ff <= csr_wdata;
      end
   end

   dtoi_round u_round (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req_valid), .in_bits(req_value_bits), .in_type(type_ff),
      .out_valid(rv), .out_ctl(rc), .out_mag(rmag)
   );

   // Stage three: clip to the target range.
   always_comb begin
      wsel = rc.ttype[1:0];
      lim = 64'd1 << ((7'd8 << wsel) - 7'd1);
      maxv = (rc.ttype == TYPE_UINT64) ? '1 : ((64'd1 << (7'd8 << wsel)) - 64'd1);
      res_in = 64'd0;
      sat_in = 1'b0;
      nan_in = 1'b0;
      if (rc.ttype == TYPE_LOGICAL) begin
         res_in = {63'd0, rc.nonzero};
      end else if (rc.ttype < TYPE_LOGICAL) begin
         if (rc.nan) begin
            nan_in = 1'b1;
         end else if (rc.ttype <= TYPE_INT64) begin
            if (rc.neg) begin
               if (rc.big || rmag > lim) begin
                  sat_in = 1'b1;
                  res_in = 64'd0 - lim;
               end else begin
                  res_in = 64'd0 - rmag;
               end
            end else if (rc.big || rmag > lim - 64'd1) begin
               sat_in = 1'b1;
               res_in = lim - 64'd1;
            end else begin
               res_in = rmag;
            end
         end else begin
            if (rc.neg) begin
               sat_in = rc.big || (rmag != 64'd0);
            end else if (rc.big || rmag > maxv) begin
               sat_in = 1'b1;
               res_in = maxv;
            end else begin
               res_in = rmag;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= rv;
      end
      if (advance) begin
         res3_ff <= res_in;
         sat3_ff <= sat_in;
         nan3_ff <= nan_in;
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_result_bits = res3_ff;
   assign rsp_saturated = sat3_ff;
   assign rsp_was_nan = nan3_ff;
endmodule
